// ----- rtl/nbt_pkg.sv -----
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared sizes, codes and control/status types of the neighbor table.
// ----------------------------------------------------------------------------
package nbt_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int DESC_BITS   = 64;

  localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W    = 32;
  localparam int PORT_W    = 16;
  localparam int RES_W     = 64;
  localparam int TIME_W    = 32;
  localparam int AGE_W     = 16;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int REMOVED_W = 6;

  localparam logic [AGE_W-1:0] EXPIRY_RST = AGE_W'(15);

  typedef enum logic [CMD_W-1:0] {
    CMD_ANNOUNCE = 2'd0,
    CMD_SWEEP    = 2'd1,
    CMD_LIST     = 2'd2
  } item_cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED  = 3'd0,
    ST_INSERTED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_SWEPT    = 3'd3,
    ST_ENTRY    = 3'd4,
    ST_EMPTY    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_ANN,
    S_SWEEP,
    S_REPORT,
    S_LIST
  } state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]    addr;
    logic [PORT_W-1:0]    port;
    logic [DESC_BITS-1:0] desc;
    logic [TIME_W-1:0]    seen;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic    in_ready;
    logic    capture;
    logic    match;
    logic    ann_update;
    logic    ann_insert;
    logic    scan_clear;
    logic    sweep_step;
    logic    sweep_end;
    logic    list_step;
    logic    out_load;
    status_e out_status;
    logic    out_last;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic             in_valid;
    logic [CMD_W-1:0] in_cmd;
    logic [CMD_W-1:0] item_cmd;
    logic             hit;
    logic             full;
    logic             scan_end;
    logic             count_zero;
    logic             list_last;
    logic             out_free;
  } dp_sts_t;

endpackage

// ----- rtl/nbt_chan_if.sv -----
// ----------------------------------------------------------------------------
// nbt_in_if / nbt_out_if
// Valid/ready channels for announce/sweep/list items and for their results.
// ----------------------------------------------------------------------------
interface nbt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] node_ip;
  logic [15:0] node_port;
  logic [63:0] node_resources;
  logic [31:0] now;

  modport source (output valid, cmd, node_ip, node_port, node_resources, now,
                  input ready);
  modport sink   (input valid, cmd, node_ip, node_port, node_resources, now,
                  output ready);
endinterface

interface nbt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [31:0] entry_ip;
  logic [15:0] entry_port;
  logic [63:0] entry_resources;
  logic [5:0]  removed_count;
  logic        last;

  modport source (output valid, status, entry_ip, entry_port, entry_resources,
                  removed_count, last, input ready);
  modport sink   (input valid, status, entry_ip, entry_port, entry_resources,
                  removed_count, last, output ready);
endinterface

// ----- rtl/neighbor_table_with_aging_core.sv -----
// ----------------------------------------------------------------------------
// neighbor_table_with_aging_core
// Ordered peer table keyed by address and port, with timeout aging.
// ----------------------------------------------------------------------------
// Items arrive on in_i (valid/ready) and results leave on out_o (valid/ready);
// a transfer happens on a clock edge with valid and ready both high. The
// expiry age is written through cfg_we_i/cfg_wdata_i; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// One item is worked at a time: in_i.ready is high only while the sequencer
// waits for an item, and the next item is taken while the last result still
// sits in the output register. Announce: the match state registers the hit
// bits, then the announce state writes the table and loads the result. Sweep:
// the sequencer walks the stored entries, one per cycle, with a read and a
// write pointer, then the result loads. List: the same sweep, then one entry
// per cycle into the output register while the receiver takes them. A stalled
// receiver holds the output register and the sequencer waits on it. Reset
// empties the table, sets the expiry age to 15 and drops any pending result;
// no clearing pass is needed. Command code 3 is taken and ignored.
// ----------------------------------------------------------------------------
module neighbor_table_with_aging_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nbt_pkg::AGE_W-1:0]  cfg_wdata_i,
  nbt_in_if.sink                     in_i,
  nbt_out_if.source                  out_o
);
  import nbt_pkg::*;

  ctrl_cmd_t ctl_cmd;
  dp_sts_t   dp_sts;

  nbt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (dp_sts),
    .cmd_o  (ctl_cmd)
  );

  nbt_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (ctl_cmd),
    .sts_o       (dp_sts),
    .in_i        (in_i),
    .out_o       (out_o)
  );

  a_load_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.out_load |-> dp_sts.out_free)
    else $error("result loaded over a pending result");

  a_no_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> !ctl_cmd.out_load)
    else $error("result loaded in the cycle of an input transfer");

  a_one_table_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_cmd.ann_update && ctl_cmd.ann_insert) &&
    !(ctl_cmd.sweep_step && (ctl_cmd.ann_update || ctl_cmd.ann_insert)))
    else $error("conflicting table writes");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.sweep_step |-> !dp_sts.scan_end)
    else $error("sweep stepped past the last entry");

  a_insert_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_cmd.ann_insert |-> (!dp_sts.full && !dp_sts.hit))
    else $error("insert into a full table or over a match");

endmodule

// ----- rtl/nbt_datapath.sv -----
// ----------------------------------------------------------------------------
// nbt_datapath
// Entry storage, parallel match, sweep pointers and the result register.
// ----------------------------------------------------------------------------
module nbt_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [nbt_pkg::AGE_W-1:0]  cfg_wdata_i,
  input  nbt_pkg::ctrl_cmd_t         cmd_i,
  output nbt_pkg::dp_sts_t           sts_o,
  nbt_in_if.sink                     in_i,
  nbt_out_if.source                  out_o
);
  import nbt_pkg::*;

  logic [AGE_W-1:0]     expiry_q;
  logic [CMD_W-1:0]     cmd_q;
  logic [ADDR_W-1:0]    ip_q;
  logic [PORT_W-1:0]    port_q;
  logic [DESC_BITS-1:0] res_q;
  logic [TIME_W-1:0]    now_q;

  logic [CNT_W-1:0]     count_q;
  logic [CNT_W-1:0]     rd_q;
  logic [CNT_W-1:0]     wr_q;
  logic [CNT_W-1:0]     removed_q;
  logic [TABLE_DEPTH-1:0] hit_q;

  entry_t               tbl_q [TABLE_DEPTH];

  logic                 out_valid_q;
  status_e              out_status_q;
  logic [ADDR_W-1:0]    out_ip_q;
  logic [PORT_W-1:0]    out_port_q;
  logic [RES_W-1:0]     out_res_q;
  logic [REMOVED_W-1:0] out_removed_q;
  logic                 out_last_q;

  logic                 hit_any;
  logic [IDX_W-1:0]     hit_idx;
  entry_t               rd_entry;
  logic [TIME_W-1:0]    age;
  logic                 keep;
  logic                 out_free;

  // entries never hold duplicates, so at most one hit bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (hit_q[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign hit_any  = |hit_q;
  assign rd_entry = tbl_q[rd_q[IDX_W-1:0]];
  assign age      = now_q - rd_entry.seen;
  assign keep     = age < TIME_W'(expiry_q);
  assign out_free = !out_valid_q || out_o.ready;

  always_comb begin
    sts_o.in_valid   = in_i.valid;
    sts_o.in_cmd     = in_i.cmd;
    sts_o.item_cmd   = cmd_q;
    sts_o.hit        = hit_any;
    sts_o.full       = count_q == CNT_W'(TABLE_DEPTH);
    sts_o.scan_end   = rd_q == count_q;
    sts_o.count_zero = count_q == '0;
    sts_o.list_last  = rd_q == (count_q - CNT_W'(1));
    sts_o.out_free   = out_free;
  end

  assign in_i.ready = cmd_i.in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q    <= EXPIRY_RST;
      count_q     <= '0;
      rd_q        <= '0;
      wr_q        <= '0;
      removed_q   <= '0;
      hit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        expiry_q <= cfg_wdata_i;
      end
      if (cmd_i.match) begin
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          hit_q[i] <= (CNT_W'(i) < count_q) && (tbl_q[i].addr == ip_q) &&
                      (tbl_q[i].port == port_q);
        end
      end
      if (cmd_i.capture) begin
        removed_q <= '0;
      end
      if (cmd_i.scan_clear) begin
        rd_q <= '0;
        wr_q <= '0;
      end
      if (cmd_i.sweep_step) begin
        rd_q <= rd_q + CNT_W'(1);
        if (keep) begin
          wr_q <= wr_q + CNT_W'(1);
        end
      end
      if (cmd_i.list_step) begin
        rd_q <= rd_q + CNT_W'(1);
      end
      if (cmd_i.sweep_end) begin
        count_q   <= wr_q;
        removed_q <= count_q - wr_q;
      end
      if (cmd_i.ann_insert) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q  <= in_i.cmd;
      ip_q   <= in_i.node_ip;
      port_q <= in_i.node_port;
      res_q  <= in_i.node_resources[DESC_BITS-1:0];
      now_q  <= in_i.now;
    end
    if (cmd_i.ann_update) begin
      tbl_q[hit_idx].desc <= res_q;
      tbl_q[hit_idx].seen <= now_q;
    end
    if (cmd_i.ann_insert) begin
      tbl_q[count_q[IDX_W-1:0]] <= '{addr: ip_q, port: port_q, desc: res_q, seen: now_q};
    end
    // compact: move a surviving entry down to the write pointer
    if (cmd_i.sweep_step && keep) begin
      tbl_q[wr_q[IDX_W-1:0]] <= rd_entry;
    end
    if (cmd_i.out_load) begin
      out_status_q  <= cmd_i.out_status;
      out_removed_q <= REMOVED_W'(removed_q);
      out_last_q    <= cmd_i.out_last;
      if (cmd_i.out_status == ST_ENTRY) begin
        out_ip_q   <= rd_entry.addr;
        out_port_q <= rd_entry.port;
        out_res_q  <= RES_W'(rd_entry.desc);
      end else begin
        out_ip_q   <= '0;
        out_port_q <= '0;
        out_res_q  <= '0;
      end
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = out_status_q;
  assign out_o.entry_ip        = out_ip_q;
  assign out_o.entry_port      = out_port_q;
  assign out_o.entry_resources = out_res_q;
  assign out_o.removed_count   = out_removed_q;
  assign out_o.last            = out_last_q;

endmodule

// ----- rtl/nbt_ctrl.sv -----
// ----------------------------------------------------------------------------
// nbt_ctrl
// Sequencer for announce, sweep/compaction and list walks.
// ----------------------------------------------------------------------------
module nbt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  nbt_pkg::dp_sts_t    sts_i,
  output nbt_pkg::ctrl_cmd_t  cmd_o
);
  import nbt_pkg::*;

  state_e state_q;
  state_e state_d;
  logic   is_list;

  assign is_list = sts_i.item_cmd == CMD_LIST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (sts_i.in_valid) begin
          case (sts_i.in_cmd)
            CMD_ANNOUNCE:     state_d = S_MATCH;
            CMD_SWEEP,
            CMD_LIST:         state_d = S_SWEEP;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_MATCH: state_d = S_ANN;
      S_ANN: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_SWEEP: begin
        if (sts_i.scan_end) begin
          state_d = S_REPORT;
        end
      end
      S_REPORT: begin
        if (is_list && !sts_i.count_zero) begin
          state_d = S_LIST;
        end else if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_LIST: begin
        if (sts_i.out_free && sts_i.list_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.out_status = ST_UPDATED;
    case (state_q)
      S_IDLE: begin
        cmd_o.in_ready   = 1'b1;
        cmd_o.capture    = sts_i.in_valid;
        cmd_o.scan_clear = sts_i.in_valid;
      end
      S_MATCH: begin
        cmd_o.match = 1'b1;
      end
      S_ANN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = 1'b1;
          if (sts_i.hit) begin
            cmd_o.ann_update = 1'b1;
            cmd_o.out_status = ST_UPDATED;
          end else if (sts_i.full) begin
            cmd_o.out_status = ST_DROPPED;
          end else begin
            cmd_o.ann_insert = 1'b1;
            cmd_o.out_status = ST_INSERTED;
          end
        end
      end
      S_SWEEP: begin
        if (sts_i.scan_end) begin
          cmd_o.sweep_end = 1'b1;
        end else begin
          cmd_o.sweep_step = 1'b1;
        end
      end
      S_REPORT: begin
        if (is_list && !sts_i.count_zero) begin
          cmd_o.scan_clear = 1'b1;
        end else if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = is_list ? ST_EMPTY : ST_SWEPT;
        end
      end
      S_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.list_step  = 1'b1;
          cmd_o.out_status = ST_ENTRY;
          cmd_o.out_last   = sts_i.list_last;
        end
      end
      default: begin
        cmd_o.in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the neighbor table. A driver feeds announce, sweep
// and list items from a queue, and a monitor compares each result transfer
// with the output of a local table model. The expiry age is changed between
// phases. The phases cover boundary ages, wrapping time, a full table and a
// zero age. Both sides insert random gaps, and long receiver hold-offs now
// and then back the block up.
// ----------------------------------------------------------------------------
module tb_top;
  import nbt_pkg::*;

  localparam logic [1:0]  CMD_UNUSED = 2'd3;
  localparam logic [63:0] DESC_MASK  = {64{1'b1}} >> (64 - DESC_BITS);
  localparam int          KEY_POOL   = 48;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] res;
    logic [31:0] now;
  } peer_item_t;

  typedef struct {
    status_e     status;
    logic [31:0] ip;
    logic [15:0] port;
    logic [63:0] res;
    logic [5:0]  removed;
    logic        last;
  } peer_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  nbt_in_if  in_if ();
  nbt_out_if out_if ();

  neighbor_table_with_aging_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // table model
  logic [31:0]  tbl_addr [TABLE_DEPTH];
  logic [15:0]  tbl_port [TABLE_DEPTH];
  logic [63:0]  tbl_desc [TABLE_DEPTH];
  logic [31:0]  tbl_seen [TABLE_DEPTH];
  int unsigned  tbl_count = 0;
  logic [15:0]  expiry_age = EXPIRY_RST;

  peer_result_t expected_results[$];
  peer_item_t   pending_items[$];
  peer_item_t   drive_item;
  peer_result_t want;

  int unsigned  in_offered   = 0;
  int unsigned  in_accepted  = 0;
  int unsigned  results_seen = 0;
  int unsigned  err_cnt      = 0;
  int unsigned  in_gap       = 0;
  int unsigned  stall_left   = 0;
  int unsigned  hold_left    = 0;
  int unsigned  next_hold_at = 40;
  bit           no_idle      = 1'b0;

  logic [31:0]  key_ip   [KEY_POOL];
  logic [15:0]  key_port [KEY_POOL];
  logic [31:0]  clock_now;

  function automatic int unsigned gap_cycles();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void post_result(status_e st, logic [31:0] ip, logic [15:0] port,
                                      logic [63:0] res, int unsigned removed, logic last);
    peer_result_t r;
    r.status  = st;
    r.ip      = ip;
    r.port    = port;
    r.res     = res;
    r.removed = removed[5:0];
    r.last    = last;
    expected_results.push_back(r);
  endfunction

  // Drop aged entries and compact the survivors in order; return the drop count.
  function automatic int unsigned age_out(logic [31:0] now);
    int unsigned keep;
    int unsigned n;
    logic [31:0] age;
    keep = 0;
    n = tbl_count;
    for (int i = 0; i < n; i++) begin
      age = now - tbl_seen[i];
      if (age >= {16'd0, expiry_age}) continue;
      tbl_addr[keep] = tbl_addr[i];
      tbl_port[keep] = tbl_port[i];
      tbl_desc[keep] = tbl_desc[i];
      tbl_seen[keep] = tbl_seen[i];
      keep++;
    end
    tbl_count = keep;
    return n - keep;
  endfunction

  function automatic void table_apply(logic [1:0] cmd, logic [31:0] ip, logic [15:0] port,
                                      logic [63:0] res, logic [31:0] now);
    int          hit;
    int unsigned removed;
    hit = -1;
    if (cmd == CMD_ANNOUNCE) begin
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_addr[i] == ip && tbl_port[i] == port) begin
          hit = i;
          break;
        end
      end
      if (hit >= 0) begin
        tbl_seen[hit] = now;
        tbl_desc[hit] = res & DESC_MASK;
        post_result(ST_UPDATED, '0, '0, '0, 0, 1'b1);
      end else if (tbl_count >= TABLE_DEPTH) begin
        post_result(ST_DROPPED, '0, '0, '0, 0, 1'b1);
      end else begin
        tbl_addr[tbl_count] = ip;
        tbl_port[tbl_count] = port;
        tbl_desc[tbl_count] = res & DESC_MASK;
        tbl_seen[tbl_count] = now;
        tbl_count++;
        post_result(ST_INSERTED, '0, '0, '0, 0, 1'b1);
      end
    end else if (cmd == CMD_SWEEP) begin
      removed = age_out(now);
      post_result(ST_SWEPT, '0, '0, '0, removed, 1'b1);
    end else if (cmd == CMD_LIST) begin
      removed = age_out(now);
      if (tbl_count == 0) begin
        post_result(ST_EMPTY, '0, '0, '0, removed, 1'b1);
      end else begin
        for (int i = 0; i < tbl_count; i++)
          post_result(ST_ENTRY, tbl_addr[i], tbl_port[i], tbl_desc[i], removed,
                      i + 1 == tbl_count);
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val, logic [63:0] got);
    if (got !== exp_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, got);
      err_cnt++;
    end
  endfunction

  // Sample both channels and the register write at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) expiry_age = cfg_wdata;
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("unexpected result, status %0d", out_if.status);
          err_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, out_if.status);
          check_field("entry_ip", want.ip, out_if.entry_ip);
          check_field("entry_port", want.port, out_if.entry_port);
          check_field("entry_resources", want.res, out_if.entry_resources);
          check_field("removed_count", want.removed, out_if.removed_count);
          check_field("last", want.last, out_if.last);
        end
      end
      if (in_if.valid && in_if.ready) begin
        in_accepted++;
        table_apply(in_if.cmd, in_if.node_ip, in_if.node_port, in_if.node_resources,
                    in_if.now);
      end
    end
  end

  // Item driver: hold the current item until its transfer, then maybe idle.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_accepted == in_offered) in_gap = no_idle ? 0 : gap_cycles();
      if (!in_if.valid || in_accepted == in_offered) begin
        if (in_gap > 0) begin
          in_gap--;
          in_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          drive_item = pending_items.pop_front();
          in_if.cmd            <= drive_item.cmd;
          in_if.node_ip        <= drive_item.ip;
          in_if.node_port      <= drive_item.port;
          in_if.node_resources <= drive_item.res;
          in_if.now            <= drive_item.now;
          in_if.valid          <= 1'b1;
          in_offered++;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls, plus a long hold-off now and then.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left == 0 && results_seen >= next_hold_at) begin
        hold_left = 300;
        next_hold_at = next_hold_at + 500;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 3) == 0) stall_left = gap_cycles();
      end
    end
  end

  task automatic push_item(logic [1:0] cmd, logic [31:0] ip, logic [15:0] port,
                           logic [63:0] res, logic [31:0] now);
    peer_item_t it;
    it.cmd  = cmd;
    it.ip   = ip;
    it.port = port;
    it.res  = res;
    it.now  = now;
    pending_items.push_back(it);
  endtask

  // Random mix over the first pool_n keys; ignored commands are extra.
  task automatic queue_mix(int n, int pool_n, int unsigned step_hi, bit jumps);
    peer_item_t  it;
    int          made;
    int unsigned pick;
    int unsigned k;
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      clock_now = clock_now + $urandom_range(0, step_hi);
      if (jumps && $urandom_range(0, 29) == 0) clock_now = $urandom;
      k = $urandom_range(0, pool_n - 1);
      it.cmd  = CMD_ANNOUNCE;
      it.ip   = key_ip[k];
      it.port = key_port[k];
      it.res  = {$urandom, $urandom};
      it.now  = clock_now;
      if (pick < 12) begin
        it.cmd = CMD_SWEEP;
      end else if (pick < 24) begin
        it.cmd = CMD_LIST;
      end else if (pick < 28) begin
        it.cmd  = CMD_UNUSED;
        it.ip   = $urandom;
        it.port = 16'($urandom_range(0, 65535));
      end
      if (it.cmd != CMD_UNUSED) made++;
      pending_items.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (!(pending_items.size() == 0 && in_accepted == in_offered &&
             expected_results.size() == 0))
      @(posedge clk);
    // let an ignored item or a trailing sweep finish
    repeat (60) @(posedge clk);
  endtask

  task automatic set_expiry(logic [15:0] age);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= age;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    logic [15:0] age_pick;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    in_if.valid          = 1'b0;
    in_if.cmd            = CMD_ANNOUNCE;
    in_if.node_ip        = '0;
    in_if.node_port      = '0;
    in_if.node_resources = '0;
    in_if.now            = '0;
    out_if.ready         = 1'b0;

    for (int k = 0; k < KEY_POOL; k++) begin
      key_ip[k]   = (k % 3 == 0 && k > 0) ? key_ip[k-1] : $urandom;
      key_port[k] = (k % 5 == 0 && k > 0) ? key_port[k-1] : 16'($urandom_range(0, 65535));
    end
    key_ip[0] = '0;
    key_port[0] = '0;
    key_ip[1] = '1;
    key_port[1] = '1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part at the reset age of 15.
    push_item(CMD_LIST, '0, '0, '0, 32'd0);
    push_item(CMD_SWEEP, '0, '0, '0, 32'd0);
    push_item(CMD_ANNOUNCE, '0, '0, '0, 32'd0);
    push_item(CMD_ANNOUNCE, '1, '1, '1, 32'hFFFF_FFFF);
    push_item(CMD_ANNOUNCE, '0, '0, 64'h0123_4567_89AB_CDEF, 32'd5);
    push_item(CMD_ANNOUNCE, '0, '1, 64'hA5A5_5A5A_F00F_0FF0, 32'd6);
    push_item(CMD_ANNOUNCE, '1, '0, 64'h8000_0000_0000_0001, 32'd7);
    push_item(CMD_UNUSED, $urandom, 16'hBEEF, {$urandom, $urandom}, $urandom);
    // wrapped last-seen stays young here
    push_item(CMD_LIST, '0, '0, '0, 32'd10);
    // age exactly 15 expires
    push_item(CMD_SWEEP, '0, '0, '0, 32'd20);
    // last-seen ahead of now reads as a huge age
    push_item(CMD_ANNOUNCE, 32'd1, 16'd1, '1, 32'd1000);
    push_item(CMD_LIST, '0, '0, '0, 32'd21);
    push_item(CMD_SWEEP, '0, '0, '0, 32'd22);
    push_item(CMD_LIST, '0, '0, '0, 32'd22);
    wait_drained();

    // Shortest age: almost everything expires.
    set_expiry(16'd1);
    clock_now = $urandom;
    queue_mix(50, 6, 1, 1'b1);
    wait_drained();

    // Longest age: fill past capacity, list a full table, then age it all out.
    set_expiry(16'hFFFF);
    clock_now = 32'd100;
    for (int k = 0; k < 40; k++) begin
      clock_now = clock_now + 1;
      push_item(CMD_ANNOUNCE, key_ip[k + 2], key_port[k + 2], {$urandom, $urandom}, clock_now);
    end
    push_item(CMD_LIST, '0, '0, '0, clock_now);
    queue_mix(30, KEY_POOL, 2, 1'b0);
    push_item(CMD_SWEEP, '0, '0, '0, clock_now + 32'd70000);
    push_item(CMD_LIST, '0, '0, '0, clock_now + 32'd70000);
    wait_drained();

    // Zero age: a sweep clears every entry.
    set_expiry(16'd0);
    queue_mix(30, 8, 3, 1'b1);
    wait_drained();

    age_pick = 16'($urandom_range(2, 200));
    set_expiry(age_pick);
    queue_mix(100, 24, age_pick / 4 + 1, 1'b1);
    wait_drained();

    // Back to the reset age, first half without idle cycles.
    set_expiry(EXPIRY_RST);
    no_idle = 1'b1;
    queue_mix(35, 40, 2, 1'b1);
    wait_drained();
    no_idle = 1'b0;
    queue_mix(40, KEY_POOL, 1, 1'b1);
    wait_drained();

    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
